// ===== rtl/twm_pkg.sv =====
// -----------------------------------------------------------------------------
// twm_pkg
// Types and constants shared by the threshold waveform meter modules.
// -----------------------------------------------------------------------------
package twm_pkg;

	localparam int SAMPLE_BITS   = 12;
	localparam int SKIP_BITS     = 8;
	localparam int MODE_BITS     = 2;
	localparam int DURATION_BITS = 24;
	localparam int APB_ADDR_BITS = 4;
	localparam int APB_DATA_BITS = 32;
	localparam int QUEUE_DEPTH   = 2;
	localparam int QUEUE_PTR_BITS = 1;
	localparam int QUEUE_CNT_BITS = 2;

	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_SKIP      = 2'd1;
	localparam logic [1:0] REG_MODE      = 2'd2;

	localparam logic [MODE_BITS-1:0] MODE_AMPLITUDE = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_HIGH_TIME = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_PERIOD    = 2'd2;

	localparam logic ACT_START  = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RESET = 12'd2048;
	localparam logic [SKIP_BITS-1:0]   SKIP_RESET      = 8'd4;
	localparam logic [MODE_BITS-1:0]   MODE_RESET      = MODE_AMPLITUDE;

	typedef struct packed {
		logic                   action;
		logic [SAMPLE_BITS-1:0] sample;
	} twm_in_t;

	typedef struct packed {
		logic [MODE_BITS-1:0]     kind;
		logic [SAMPLE_BITS-1:0]   high_level;
		logic [SAMPLE_BITS-1:0]   low_level;
		logic [DURATION_BITS-1:0] duration;
	} twm_out_t;

	typedef struct packed {
		logic                   start;
		logic                   high;
		logic                   above;
		logic [SAMPLE_BITS-1:0] sample;
	} twm_cls_t;

	typedef struct packed {
		logic [SKIP_BITS-1:0] skip_samples;
		logic [MODE_BITS-1:0] mode;
	} twm_cfg_t;

endpackage

// ===== rtl/threshold_waveform_measure_top.sv =====
// -----------------------------------------------------------------------------
// threshold_waveform_measure_top
// Threshold-crossing meter for converter samples: amplitude, high time and
// period, one result per finished measurement.
// -----------------------------------------------------------------------------
// The block takes one input beat per clock cycle, start commands and samples
// alike, and keeps that rate as long as results are taken. The input stage
// registers each beat with its threshold compare, a two-entry queue follows,
// and the sequencer steps once per beat; a result passes through the input
// stage register, the queue and the output register. A stalled result holds
// the sequencer; the queue and input stage then fill and stall the input after
// at most three more beats. The user must write registers over the APB port
// only while no measurement beat is in flight; the block does not enforce it.
module threshold_waveform_measure_top #(
	parameter int COUNT_BITS = 24
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [twm_pkg::APB_ADDR_BITS-1:0]  paddr,
	input  logic [twm_pkg::APB_DATA_BITS-1:0]  pwdata,
	output logic [twm_pkg::APB_DATA_BITS-1:0]  prdata,
	output logic                               pready,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  twm_pkg::twm_in_t                   in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output twm_pkg::twm_out_t                  out_data
);
	import twm_pkg::*;

	logic     cls_valid;
	logic     cls_ready;
	twm_cls_t cls;
	twm_cfg_t cfg;
	logic     q_valid;
	logic     q_pop;
	twm_cls_t q_data;

	twm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.cls_valid (cls_valid),
		.cls_ready (cls_ready),
		.cls       (cls),
		.cfg       (cfg)
	);

	twm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (cls_valid),
		.push_ready (cls_ready),
		.push_data  (cls),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_data   (q_data)
	);

	twm_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_data    (q_data),
		.cfg       (cfg),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// ===== rtl/twm_front.sv =====
// -----------------------------------------------------------------------------
// twm_front
// Register file and input stage: compares each sample with the threshold
// and hands classified beats to the queue.
// -----------------------------------------------------------------------------
module twm_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [twm_pkg::APB_ADDR_BITS-1:0]  paddr,
	input  logic [twm_pkg::APB_DATA_BITS-1:0]  pwdata,
	output logic [twm_pkg::APB_DATA_BITS-1:0]  prdata,
	output logic                               pready,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  twm_pkg::twm_in_t                   in_data,
	output logic                               cls_valid,
	input  logic                               cls_ready,
	output twm_pkg::twm_cls_t                  cls,
	output twm_pkg::twm_cfg_t                  cfg
);
	import twm_pkg::*;

	logic [SAMPLE_BITS-1:0] threshold_q;
	logic [SKIP_BITS-1:0]   skip_q;
	logic [MODE_BITS-1:0]   mode_q;
	logic [1:0]             reg_idx;
	logic                   wr_en;
	logic                   valid_s1;
	twm_cls_t               cls_s1;
	logic                   take;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
			skip_q      <= SKIP_RESET;
			mode_q      <= MODE_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_THRESHOLD: threshold_q <= pwdata[SAMPLE_BITS-1:0];
				REG_SKIP:      skip_q      <= pwdata[SKIP_BITS-1:0];
				REG_MODE:      mode_q      <= pwdata[MODE_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_THRESHOLD: prdata = APB_DATA_BITS'(threshold_q);
			REG_SKIP:      prdata = APB_DATA_BITS'(skip_q);
			REG_MODE:      prdata = APB_DATA_BITS'(mode_q);
			default:       prdata = '0;
		endcase
	end

	assign cfg.skip_samples = skip_q;
	assign cfg.mode         = mode_q;

	// advance the stage when it is empty or its beat moves on
	assign in_stall = valid_s1 && !cls_ready;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cls_s1.start  <= (in_data.action == ACT_START);
			cls_s1.high   <= (in_data.sample >= threshold_q);
			cls_s1.above  <= (in_data.sample > threshold_q);
			cls_s1.sample <= in_data.sample;
		end
	end

	assign cls_valid = valid_s1;
	assign cls       = cls_s1;

endmodule

// ===== rtl/twm_queue.sv =====
// -----------------------------------------------------------------------------
// twm_queue
// Short queue of classified beats between the input stage and the
// measurement engine.
// -----------------------------------------------------------------------------
module twm_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  twm_pkg::twm_cls_t push_data,
	output logic              pop_valid,
	input  logic              pop,
	output twm_pkg::twm_cls_t pop_data
);
	import twm_pkg::*;

	twm_cls_t                  mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_BITS-1:0] wr_ptr_q;
	logic [QUEUE_PTR_BITS-1:0] rd_ptr_q;
	logic [QUEUE_CNT_BITS-1:0] cnt_q;
	logic                      do_push;
	logic                      do_pop;

	assign push_ready = (cnt_q != QUEUE_CNT_BITS'(QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/twm_back.sv =====
// -----------------------------------------------------------------------------
// twm_back
// Measurement engine: steps the measurement sequencer once per classified
// beat and holds the finished result in the output register.
// -----------------------------------------------------------------------------
module twm_back #(
	parameter int COUNT_BITS = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_pop,
	input  twm_pkg::twm_cls_t q_data,
	input  twm_pkg::twm_cfg_t cfg,
	output logic              out_valid,
	input  logic              out_stall,
	output twm_pkg::twm_out_t out_data
);
	import twm_pkg::*;

	localparam logic [3:0] PH_IDLE    = 4'd0;
	localparam logic [3:0] PH_A_RISE  = 4'd1;
	localparam logic [3:0] PH_A_SKIP1 = 4'd2;
	localparam logic [3:0] PH_A_CAPH  = 4'd3;
	localparam logic [3:0] PH_A_FALL  = 4'd4;
	localparam logic [3:0] PH_A_SKIP2 = 4'd5;
	localparam logic [3:0] PH_A_CAPL  = 4'd6;
	localparam logic [3:0] PH_H_FIRST = 4'd7;
	localparam logic [3:0] PH_H_FALL  = 4'd8;
	localparam logic [3:0] PH_H_SKIP  = 4'd9;
	localparam logic [3:0] PH_H_RISE  = 4'd10;
	localparam logic [3:0] PH_H_COUNT = 4'd11;
	localparam logic [3:0] PH_P_RISE  = 4'd12;
	localparam logic [3:0] PH_P_HIGH  = 4'd13;
	localparam logic [3:0] PH_P_LOW   = 4'd14;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam int EXT_BITS = COUNT_BITS + DURATION_BITS;

	logic [3:0]             phase_q;
	logic [SKIP_BITS-1:0]   skip_left_q;
	logic [COUNT_BITS-1:0]  run_count_q;
	logic [SAMPLE_BITS-1:0] held_high_q;
	logic                   out_valid_q;
	twm_out_t               out_q;

	logic [3:0]             n_phase;
	logic [SKIP_BITS-1:0]   n_skip_left;
	logic [COUNT_BITS-1:0]  n_run_count;
	logic [SAMPLE_BITS-1:0] n_held_high;
	logic                   emit;
	twm_out_t               emit_data;
	logic [COUNT_BITS-1:0]  count_inc;
	logic [SKIP_BITS-1:0]   skip_dec;
	logic [EXT_BITS-1:0]    count_ext;
	logic [DURATION_BITS-1:0] count_dur;

	// hold the queue while a result waits to be taken
	assign q_pop = q_valid && (!out_valid_q || !out_stall);

	assign count_inc = (run_count_q == COUNT_MAX) ? run_count_q : run_count_q + 1'b1;
	assign skip_dec  = skip_left_q - 1'b1;
	assign count_ext = EXT_BITS'(run_count_q);
	assign count_dur = count_ext[DURATION_BITS-1:0];

	always_comb begin
		n_phase     = phase_q;
		n_skip_left = skip_left_q;
		n_run_count = run_count_q;
		n_held_high = held_high_q;
		emit        = 1'b0;
		emit_data   = '0;
		if (q_data.start) begin
			n_skip_left = '0;
			n_run_count = '0;
			n_held_high = '0;
			unique case (cfg.mode)
				MODE_AMPLITUDE: n_phase = PH_A_RISE;
				MODE_HIGH_TIME: n_phase = PH_H_FIRST;
				MODE_PERIOD:    n_phase = PH_P_RISE;
				default:        n_phase = PH_IDLE;
			endcase
		end else begin
			unique case (phase_q)
				PH_A_RISE: begin
					if (q_data.high) begin
						n_skip_left = cfg.skip_samples;
						n_phase     = (cfg.skip_samples == '0) ? PH_A_CAPH : PH_A_SKIP1;
					end
				end
				PH_A_SKIP1: begin
					n_skip_left = skip_dec;
					if (skip_dec == '0) begin
						n_phase = PH_A_CAPH;
					end
				end
				PH_A_CAPH: begin
					n_held_high = q_data.sample;
					n_phase     = PH_A_FALL;
				end
				PH_A_FALL: begin
					if (!q_data.high) begin
						n_skip_left = cfg.skip_samples;
						n_phase     = (cfg.skip_samples == '0) ? PH_A_CAPL : PH_A_SKIP2;
					end
				end
				PH_A_SKIP2: begin
					n_skip_left = skip_dec;
					if (skip_dec == '0) begin
						n_phase = PH_A_CAPL;
					end
				end
				PH_A_CAPL: begin
					emit                 = 1'b1;
					emit_data.kind       = MODE_AMPLITUDE;
					emit_data.high_level = held_high_q;
					emit_data.low_level  = q_data.sample;
					n_phase              = PH_IDLE;
				end
				PH_H_FIRST: begin
					n_phase = q_data.above ? PH_H_FALL : PH_H_RISE;
				end
				PH_H_FALL: begin
					if (!q_data.high) begin
						n_skip_left = cfg.skip_samples;
						n_phase     = (cfg.skip_samples == '0) ? PH_H_RISE : PH_H_SKIP;
					end
				end
				PH_H_SKIP: begin
					n_skip_left = skip_dec;
					if (skip_dec == '0) begin
						n_phase = PH_H_RISE;
					end
				end
				PH_H_RISE: begin
					if (q_data.high) begin
						n_run_count = COUNT_BITS'(1);
						n_phase     = PH_H_COUNT;
					end
				end
				PH_H_COUNT: begin
					if (q_data.high) begin
						n_run_count = count_inc;
					end else begin
						emit               = 1'b1;
						emit_data.kind     = MODE_HIGH_TIME;
						emit_data.duration = count_dur;
						n_phase            = PH_IDLE;
					end
				end
				PH_P_RISE: begin
					if (q_data.high) begin
						n_run_count = '0;
						n_phase     = PH_P_HIGH;
					end
				end
				PH_P_HIGH: begin
					if (q_data.high) begin
						n_run_count = count_inc;
					end else begin
						n_phase = PH_P_LOW;
					end
				end
				PH_P_LOW: begin
					if (!q_data.high) begin
						n_run_count = count_inc;
					end else begin
						emit               = 1'b1;
						emit_data.kind     = MODE_PERIOD;
						emit_data.duration = count_dur;
						n_phase            = PH_IDLE;
					end
				end
				default: begin
					n_phase = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			skip_left_q <= '0;
			run_count_q <= '0;
			held_high_q <= '0;
		end else if (q_pop) begin
			phase_q     <= n_phase;
			skip_left_q <= n_skip_left;
			run_count_q <= n_run_count;
			held_high_q <= n_held_high;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= emit;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && emit) begin
			out_q <= emit_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== rtl/twm_checker.sv =====
// -----------------------------------------------------------------------------
// twm_checker
// Port-level checks for the threshold waveform meter, bound to the top level.
// -----------------------------------------------------------------------------
module twm_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               psel,
	input logic                               penable,
	input logic                               pready,
	input logic                               out_valid,
	input logic                               out_stall,
	input twm_pkg::twm_out_t                  out_data
);
	import twm_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result beat changed or dropped");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.kind == MODE_AMPLITUDE || out_data.kind == MODE_HIGH_TIME
			|| out_data.kind == MODE_PERIOD))
		else $error("result kind out of range");

	a_amp_dur: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind == MODE_AMPLITUDE |-> out_data.duration == '0)
		else $error("amplitude result carries a duration");

	a_count_lvl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind != MODE_AMPLITUDE
			|-> out_data.high_level == '0 && out_data.low_level == '0)
		else $error("count result carries levels");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable |-> pready)
		else $error("register access not completed");

endmodule

bind threshold_waveform_measure_top twm_checker u_twm_checker (.*);
